@@ rtl/vrsd_pkg.sv @@
// shared types, codes and reset values for the video region stream detector
// no dependencies
package vrsd_pkg;

    localparam int NumStreamIdsDef  = 8;
    localparam int NumCandidatesDef = 16;

    localparam logic [23:0] MinAreaRst   = 24'd10000;
    localparam logic [30:0] CandToutRst  = 31'd200;
    localparam logic [30:0] StreamToutRst = 31'd1000;
    localparam logic [7:0]  StartCountRst = 8'd20;

    typedef enum logic [1:0] {
        KIND_RECT  = 2'd0,
        KIND_CHECK = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_MIN_AREA     = 2'd0,
        REG_CAND_TIMEOUT = 2'd1,
        REG_STRM_TIMEOUT = 2'd2,
        REG_START_COUNT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] right;
        logic [11:0] top;
        logic [11:0] bottom;
    } rect_t;

    // broadcast to every candidate cell
    typedef struct packed {
        logic        clear;
        logic        big;
        rect_t       rect;
        logic [31:0] now;
        logic [30:0] timeout;
        logic [7:0]  start_count;
    } cand_cmd_t;

    // answer of the cell holding the token, all zero elsewhere
    typedef struct packed {
        logic active;
        logic free_after;
        logic matched;
        logic promote;
    } cand_rsp_t;

    // broadcast to every stream cell
    typedef struct packed {
        logic        clear;
        logic        sweep;
        logic        refresh;
        rect_t       rect;
        logic [31:0] now;
        logic [30:0] timeout;
    } strm_cmd_t;

    // signed-difference staleness test
    function automatic logic stale(input logic [31:0] now, input logic [31:0] then,
                                   input logic [30:0] limit);
        logic [31:0] d;
        d = now - then;
        return !d[31] && (d[30:0] > limit);
    endfunction

endpackage

@@ rtl/video_region_stream_detector.sv @@
// top level of the video region stream detector: control, registers, cell rows
// depends on vrsd_pkg, vrsd_cand_cell, vrsd_strm_cell
//
// A rectangle update item passes from acceptance to its result being offered
// through the area product, the parallel stream expiry and refresh, a token
// walk through every candidate cell, storing of a new candidate and the load
// of the result register, held while a stalled result is pending. Timeout
// checks skip the walk and store; clears and the unused kind skip the stream
// step too. The result waits in its own register, so the next item is taken
// while it is still pending. The user must write configuration registers with
// cfg_we, cfg_index and cfg_data while the block is idle; it is not enforced.
module video_region_stream_detector
#(
    parameter int NUM_STREAM_IDS = vrsd_pkg::NumStreamIdsDef,
    parameter int NUM_CANDIDATES = vrsd_pkg::NumCandidatesDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [11:0] rect_left,
    input  logic [11:0] rect_right,
    input  logic [11:0] rect_top,
    input  logic [11:0] rect_bottom,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        streaming,
    output logic        stream_created,
    output logic [2:0]  created_id,
    output logic        id_unavailable,
    output logic        candidate_dropped,
    output logic [7:0]  live_mask
);

    localparam int PadW = (NUM_STREAM_IDS > 8) ? NUM_STREAM_IDS : 8;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_AREA   = 6'b000010,
        S_STREAM = 6'b000100,
        S_CAND   = 6'b001000,
        S_INS    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0] min_area_reg;
    logic [30:0] cand_tout_reg;
    logic [30:0] strm_tout_reg;
    logic [7:0]  start_count_reg;

    logic [1:0]      kind_reg;
    vrsd_pkg::rect_t rect_reg;
    logic [31:0]     now_reg;
    logic            large_reg;
    logic            matched_reg;
    logic            created_reg;
    logic [2:0]      id_reg;
    logic            no_id_reg;
    logic            slot_found_reg;
    logic [NUM_CANDIDATES-1:0] slot_oh_reg;

    logic signed [12:0] dx;
    logic signed [12:0] dy;
    logic signed [25:0] area;

    vrsd_pkg::cand_cmd_t ccmd;
    vrsd_pkg::strm_cmd_t scmd;
    vrsd_pkg::cand_rsp_t crsp [NUM_CANDIDATES];
    logic [NUM_CANDIDATES:0]   tok;
    logic [NUM_CANDIDATES-1:0] act;
    logic [NUM_CANDIDATES-1:0] ins_oh;
    logic any_free, any_match, any_promote;

    logic [NUM_STREAM_IDS-1:0] live;
    logic [NUM_STREAM_IDS-1:0] free_oh;
    logic [NUM_STREAM_IDS-1:0] create_oh;
    logic [2:0]                free_id;
    logic [PadW-1:0]           live_pad;
    logic                      do_clear;
    logic                      do_load;

    assign in_stall = (state_reg != S_IDLE);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_area_reg    <= vrsd_pkg::MinAreaRst;
            cand_tout_reg   <= vrsd_pkg::CandToutRst;
            strm_tout_reg   <= vrsd_pkg::StreamToutRst;
            start_count_reg <= vrsd_pkg::StartCountRst;
        end
        else if (cfg_we)
        begin
            case (vrsd_pkg::reg_idx_t'(cfg_index))
                vrsd_pkg::REG_MIN_AREA:     min_area_reg    <= cfg_data[23:0];
                vrsd_pkg::REG_CAND_TIMEOUT: cand_tout_reg   <= cfg_data;
                vrsd_pkg::REG_STRM_TIMEOUT: strm_tout_reg   <= cfg_data;
                vrsd_pkg::REG_START_COUNT:  start_count_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // area product
    always_comb
    begin
        dx   = $signed({1'b0, rect_reg.right}) - $signed({1'b0, rect_reg.left});
        dy   = $signed({1'b0, rect_reg.bottom}) - $signed({1'b0, rect_reg.top});
        area = dx * dy;
    end

    // aggregate the token holder's answer
    always_comb
    begin
        any_free    = 1'b0;
        any_match   = 1'b0;
        any_promote = 1'b0;
        for (int i = 0; i < NUM_CANDIDATES; i++)
        begin
            act[i]      = crsp[i].active;
            any_free    = any_free | crsp[i].free_after;
            any_match   = any_match | crsp[i].matched;
            any_promote = any_promote | crsp[i].promote;
        end
    end

    // lowest free stream id
    always_comb
    begin
        free_oh = ~live & (live + NUM_STREAM_IDS'(1));
        free_id = 3'd0;
        for (int k = 0; k < NUM_STREAM_IDS; k++)
        begin
            if (free_oh[k])
                free_id = free_id | 3'(k);
        end
        create_oh = (state_reg == S_CAND && any_promote) ? free_oh : '0;
        live_pad  = PadW'(live);
    end

    assign do_clear = (state_reg == S_AREA) && (kind_reg == vrsd_pkg::KIND_CLEAR);
    assign ins_oh   = (state_reg == S_INS && large_reg && !matched_reg && slot_found_reg)
                      ? slot_oh_reg : '0;
    assign tok[0]   = (state_reg == S_STREAM) && (kind_reg == vrsd_pkg::KIND_RECT);
    assign do_load  = (state_reg == S_DONE) && (!out_valid || !out_stall);

    always_comb
    begin
        ccmd.clear       = do_clear;
        ccmd.big         = large_reg;
        ccmd.rect        = rect_reg;
        ccmd.now         = now_reg;
        ccmd.timeout     = cand_tout_reg;
        ccmd.start_count = start_count_reg;
        scmd.clear       = do_clear;
        scmd.sweep       = (state_reg == S_STREAM);
        scmd.refresh     = large_reg && (kind_reg == vrsd_pkg::KIND_RECT);
        scmd.rect        = rect_reg;
        scmd.now         = now_reg;
        scmd.timeout     = strm_tout_reg;
    end

    for (genvar g = 0; g < NUM_CANDIDATES; g++)
    begin : g_cand
        vrsd_cand_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (ccmd),
            .ins     (ins_oh[g]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .rsp     (crsp[g])
        );
    end

    for (genvar g = 0; g < NUM_STREAM_IDS; g++)
    begin : g_strm
        vrsd_strm_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (scmd),
            .create (create_oh[g]),
            .live   (live[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_AREA;
            S_AREA:
            begin
                if (kind_reg == vrsd_pkg::KIND_RECT || kind_reg == vrsd_pkg::KIND_CHECK)
                    state_next = S_STREAM;
                else
                    state_next = S_DONE;
            end
            S_STREAM:
            begin
                if (kind_reg == vrsd_pkg::KIND_RECT)
                    state_next = S_CAND;
                else
                    state_next = S_DONE;
            end
            S_CAND:   if (act[NUM_CANDIDATES-1]) state_next = S_INS;
            S_INS:    state_next = S_DONE;
            S_DONE:   if (do_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid         <= 1'b0;
            matched_reg       <= 1'b0;
            created_reg       <= 1'b0;
            no_id_reg         <= 1'b0;
            slot_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_load)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
            if (state_reg == S_IDLE)
            begin
                matched_reg    <= 1'b0;
                created_reg    <= 1'b0;
                no_id_reg      <= 1'b0;
                slot_found_reg <= 1'b0;
            end
            else if (state_reg == S_CAND)
            begin
                if (any_match)
                    matched_reg <= 1'b1;
                if (any_promote && (|free_oh))
                    created_reg <= 1'b1;
                if (any_promote && !(|free_oh))
                    no_id_reg <= 1'b1;
                if (any_free && !slot_found_reg)
                    slot_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            kind_reg    <= kind;
            rect_reg    <= '{left: rect_left, right: rect_right,
                             top: rect_top, bottom: rect_bottom};
            now_reg     <= timestamp;
        end
        if (state_reg == S_AREA)
            large_reg <= (27'(area) > $signed({3'b000, min_area_reg}));
        if (state_reg == S_CAND)
        begin
            if (any_promote && (|free_oh))
                id_reg <= free_id;
            if (any_free && !slot_found_reg)
                slot_oh_reg <= act;
        end
        if (do_load)
        begin
            streaming         <= |live;
            stream_created    <= created_reg;
            created_id        <= created_reg ? id_reg : 3'd0;
            id_unavailable    <= no_id_reg;
            candidate_dropped <= (kind_reg == vrsd_pkg::KIND_RECT) && large_reg
                                 && !matched_reg && !slot_found_reg;
            live_mask         <= live_pad[7:0];
        end
    end

    a_create_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(stream_created && id_unavailable))
        else $error("stream created and id unavailable together");

    a_create_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_created |-> streaming)
        else $error("stream created but none live");

    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && candidate_dropped |-> !stream_created && !id_unavailable)
        else $error("dropped candidate alongside a match");

endmodule

@@ rtl/vrsd_cand_cell.sv @@
// one candidate table entry with its place in the walk token chain
// depends on vrsd_pkg
module vrsd_cand_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  vrsd_pkg::cand_cmd_t cmd,
    input  logic                ins,
    input  logic                tok_in,
    output logic                tok_out,
    output vrsd_pkg::cand_rsp_t rsp
);

    logic              tok_reg;
    logic              valid_reg;
    logic              valid_next;
    vrsd_pkg::rect_t   rect_reg;
    logic [31:0]       last_reg;
    logic [7:0]        hits_reg;
    logic [7:0]        hits_inc;
    logic              live;
    logic              hit;
    logic              promote;

    always_comb
    begin
        hits_inc = (hits_reg == 8'hFF) ? hits_reg : hits_reg + 8'd1;
        live     = valid_reg && !vrsd_pkg::stale(cmd.now, last_reg, cmd.timeout);
        hit      = live && cmd.big && (cmd.rect == rect_reg);
        promote  = hit && (hits_inc >= cmd.start_count);
        valid_next = live && !promote;
        rsp.active     = tok_reg;
        rsp.free_after = tok_reg && !valid_next;
        rsp.matched    = tok_reg && hit;
        rsp.promote    = tok_reg && promote;
    end

    assign tok_out = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (cmd.clear)
                valid_reg <= 1'b0;
            else if (ins)
                valid_reg <= 1'b1;
            else if (tok_reg)
                valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            rect_reg <= cmd.rect;
            last_reg <= cmd.now;
            hits_reg <= 8'd1;
        end
        else if (tok_reg && hit)
        begin
            last_reg <= cmd.now;
            hits_reg <= hits_inc;
        end
    end

endmodule

@@ rtl/vrsd_strm_cell.sv @@
// one stream id entry: expiry, refresh on containment, creation
// depends on vrsd_pkg
module vrsd_strm_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  vrsd_pkg::strm_cmd_t cmd,
    input  logic                create,
    output logic                live
);

    logic            live_reg;
    vrsd_pkg::rect_t rect_reg;
    logic [31:0]     last_reg;
    logic            is_stale;
    logic            holds;

    always_comb
    begin
        is_stale = vrsd_pkg::stale(cmd.now, last_reg, cmd.timeout);
        holds = (cmd.rect.left <= rect_reg.left) && (cmd.rect.right >= rect_reg.right)
             && (cmd.rect.top <= rect_reg.top) && (cmd.rect.bottom >= rect_reg.bottom);
    end

    assign live = live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= 1'b0;
        else if (cmd.clear)
            live_reg <= 1'b0;
        else if (create)
            live_reg <= 1'b1;
        else if (cmd.sweep && live_reg && is_stale)
            live_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (create)
        begin
            rect_reg <= cmd.rect;
            last_reg <= cmd.now;
        end
        else if (cmd.sweep && cmd.refresh && live_reg && !is_stale && holds)
            last_reg <= cmd.now;
    end

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the video region stream detector
// depends on vrsd_pkg and video_region_stream_detector; predicts every result item
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        vrsd_pkg::kind_t kind;
        vrsd_pkg::rect_t rect;
        logic [31:0]     ts;
    } job_t;

    typedef struct packed {
        logic       streaming;
        logic       created;
        logic [2:0] id;
        logic       no_id;
        logic       dropped;
        logic [7:0] mask;
    } verdict_t;

    localparam int NC = vrsd_pkg::NumCandidatesDef;
    localparam int NS = vrsd_pkg::NumStreamIdsDef;
    localparam int WATCHDOG = 20000;

    logic clk, rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [30:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] kind;
    logic [11:0] rect_left, rect_right, rect_top, rect_bottom;
    logic [31:0] timestamp;
    logic streaming, stream_created, id_unavailable, candidate_dropped;
    logic [2:0] created_id;
    logic [7:0] live_mask;

    video_region_stream_detector dut (.*);

    // predictor state
    logic [23:0]     p_min_area;
    logic [30:0]     p_cand_tout, p_strm_tout;
    logic [7:0]      p_start;
    logic            c_valid [NC];
    vrsd_pkg::rect_t c_rect [NC];
    logic [31:0]     c_seen [NC];
    logic [7:0]      c_hits [NC];
    logic            s_live [NS];
    vrsd_pkg::rect_t s_rect [NS];
    logic [31:0]     s_seen [NS];

    job_t     pending_items[$];
    verdict_t expected_results[$];
    int errors, accepted_in, idle_cycles;
    int send_idle, recv_idle;
    logic [31:0] now_t;

    function automatic logic is_old(logic [31:0] n, logic [31:0] t, logic [30:0] lim);
        logic [31:0] d;
        d = n - t;
        return !d[31] && d[30:0] > lim;
    endfunction

    task automatic predict_item(input job_t j);
        verdict_t v;
        logic signed [31:0] dx, dy;
        logic big, hit;
        int slot, fid;
        v = '0;
        if (j.kind == vrsd_pkg::KIND_RECT)
        begin
            dx = $signed({20'd0, j.rect.right}) - $signed({20'd0, j.rect.left});
            dy = $signed({20'd0, j.rect.bottom}) - $signed({20'd0, j.rect.top});
            big = (dx * dy) > $signed({8'd0, p_min_area});
            hit = 1'b0;
            for (int i = 0; i < NS; i++)
                if (s_live[i])
                begin
                    if (is_old(j.ts, s_seen[i], p_strm_tout)) s_live[i] = 1'b0;
                    else if (big && j.rect.left <= s_rect[i].left
                             && j.rect.right >= s_rect[i].right
                             && j.rect.top <= s_rect[i].top
                             && j.rect.bottom >= s_rect[i].bottom)
                        s_seen[i] = j.ts;
                end
            for (int i = 0; i < NC; i++)
                if (c_valid[i])
                begin
                    if (is_old(j.ts, c_seen[i], p_cand_tout)) c_valid[i] = 1'b0;
                    else if (big && j.rect == c_rect[i])
                    begin
                        hit = 1'b1;
                        if (c_hits[i] != 8'hff) c_hits[i] = c_hits[i] + 8'd1;
                        c_seen[i] = j.ts;
                        if (c_hits[i] >= p_start)
                        begin
                            fid = -1;
                            for (int k = NS - 1; k >= 0; k--)
                                if (!s_live[k]) fid = k;
                            if (fid >= 0)
                            begin
                                s_live[fid] = 1'b1;
                                s_rect[fid] = j.rect;
                                s_seen[fid] = j.ts;
                                v.created = 1'b1;
                                v.id = fid[2:0];
                            end
                            else v.no_id = 1'b1;
                            c_valid[i] = 1'b0;
                        end
                    end
                end
            if (!hit && big)
            begin
                slot = -1;
                for (int i = NC - 1; i >= 0; i--)
                    if (!c_valid[i]) slot = i;
                if (slot >= 0)
                begin
                    c_valid[slot] = 1'b1;
                    c_rect[slot] = j.rect;
                    c_seen[slot] = j.ts;
                    c_hits[slot] = 8'd1;
                end
                else v.dropped = 1'b1;
            end
        end
        else if (j.kind == vrsd_pkg::KIND_CHECK)
        begin
            for (int i = 0; i < NS; i++)
                if (s_live[i] && is_old(j.ts, s_seen[i], p_strm_tout)) s_live[i] = 1'b0;
        end
        else if (j.kind == vrsd_pkg::KIND_CLEAR)
        begin
            for (int i = 0; i < NC; i++) c_valid[i] = 1'b0;
            for (int i = 0; i < NS; i++) s_live[i] = 1'b0;
        end
        for (int i = 0; i < NS; i++)
            if (s_live[i])
            begin
                v.streaming = 1'b1;
                v.mask[i] = 1'b1;
            end
        expected_results = {expected_results, v};
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
        if (!rst_n)
        begin
            in_valid <= 0;
            kind <= '0; rect_left <= '0; rect_right <= '0;
            rect_top <= '0; rect_bottom <= '0; timestamp <= '0;
        end
        else
        begin
            job_t j;
            if (!(in_valid && in_stall))
            begin
                if (in_valid) accepted_in++;
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    j = pending_items.pop_front();
                    predict_item(j);
                    in_valid <= 1;
                    kind <= j.kind;
                    rect_left <= j.rect.left; rect_right <= j.rect.right;
                    rect_top <= j.rect.top; rect_bottom <= j.rect.bottom;
                    timestamp <= j.ts;
                end
                else in_valid <= 0;
            end
        end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
        if (!rst_n)
        begin
            out_stall <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            verdict_t got, want;
            out_stall <= ($urandom_range(99) < recv_idle);
            idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall))
                           ? 0 : idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                got = {streaming, stream_created, created_id, id_unavailable,
                       candidate_dropped, live_mask};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected result item %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Some tests failed");
                $finish;
            end
        end

    function automatic vrsd_pkg::rect_t any_rect();
        vrsd_pkg::rect_t r;
        r.left = 12'($urandom); r.right = 12'($urandom);
        r.top = 12'($urandom); r.bottom = 12'($urandom);
        return r;
    endfunction

    task automatic add_item(input vrsd_pkg::kind_t k, input vrsd_pkg::rect_t r,
                            input logic [31:0] t);
        job_t j;
        j.kind = k; j.rect = r; j.ts = t;
        pending_items = {pending_items, j};
    endtask

    task automatic write_reg(input vrsd_pkg::reg_idx_t idx, input logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            vrsd_pkg::REG_MIN_AREA:     p_min_area = val[23:0];
            vrsd_pkg::REG_CAND_TIMEOUT: p_cand_tout = val;
            vrsd_pkg::REG_STRM_TIMEOUT: p_strm_tout = val;
            vrsd_pkg::REG_START_COUNT:  p_start = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // a burst of well-formed repeating rectangles with noise
    task automatic random_phase(input int n);
        vrsd_pkg::rect_t pool [6];
        vrsd_pkg::rect_t r;
        int p;
        for (int i = 0; i < 6; i++)
        begin
            pool[i].left = 12'($urandom_range(2000)); pool[i].top = 12'($urandom_range(2000));
            pool[i].right = 12'(pool[i].left + $urandom_range(1500, 50));
            pool[i].bottom = 12'(pool[i].top + $urandom_range(1500, 50));
        end
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(99);
            now_t = now_t + (($urandom_range(9) == 0) ? $urandom : $urandom_range(40));
            if (p < 65) add_item(vrsd_pkg::KIND_RECT, pool[$urandom_range(5)], now_t);
            else if (p < 75)
            begin
                r.left = 12'd0; r.top = 12'd0; r.right = 12'hfff; r.bottom = 12'hfff;
                add_item(vrsd_pkg::KIND_RECT, r, now_t);
            end
            else if (p < 88) add_item(vrsd_pkg::KIND_RECT, any_rect(), now_t);
            else if (p < 95) add_item(vrsd_pkg::KIND_CHECK, any_rect(), now_t);
            else if (p < 98) add_item(vrsd_pkg::KIND_NONE, any_rect(), now_t);
            else add_item(vrsd_pkg::KIND_CLEAR, any_rect(), now_t);
        end
    endtask

    initial
    begin
        vrsd_pkg::rect_t r;
        errors = 0; accepted_in = 0;
        send_idle = 0; recv_idle = 0;
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        p_min_area = vrsd_pkg::MinAreaRst; p_cand_tout = vrsd_pkg::CandToutRst;
        p_strm_tout = vrsd_pkg::StreamToutRst; p_start = vrsd_pkg::StartCountRst;
        for (int i = 0; i < NC; i++) c_valid[i] = 1'b0;
        for (int i = 0; i < NS; i++) s_live[i] = 1'b0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        now_t = 32'h7fff_fff0;

        // directed: reset settings, edge fields, all kinds
        r = '0; add_item(vrsd_pkg::KIND_RECT, r, 32'd0);
        r = '1; add_item(vrsd_pkg::KIND_RECT, r, 32'hffff_ffff);
        r.left = 12'd0; r.right = 12'hfff; r.top = 12'd0; r.bottom = 12'hfff;
        add_item(vrsd_pkg::KIND_RECT, r, 32'd10);
        r.left = 12'hfff; r.right = 12'd0; r.top = 12'd0; r.bottom = 12'hfff;
        add_item(vrsd_pkg::KIND_RECT, r, 32'd11);
        r.left = 12'hfff; r.right = 12'd0; r.top = 12'hfff; r.bottom = 12'd0;
        add_item(vrsd_pkg::KIND_RECT, r, 32'd12);
        add_item(vrsd_pkg::KIND_CHECK, '1, 32'h8000_0000);
        add_item(vrsd_pkg::KIND_NONE, '0, 32'd5);
        add_item(vrsd_pkg::KIND_CLEAR, '1, 32'd6);
        drain();

        // start count one, tiny thresholds: streams form fast, ids run out
        write_reg(vrsd_pkg::REG_START_COUNT, 31'd1);
        write_reg(vrsd_pkg::REG_MIN_AREA, 31'd0);
        write_reg(vrsd_pkg::REG_CAND_TIMEOUT, 31'h7fff_ffff);
        write_reg(vrsd_pkg::REG_STRM_TIMEOUT, 31'h7fff_ffff);
        for (int i = 0; i < 12; i++)
        begin
            r.left = 12'(i); r.right = 12'(i + 5); r.top = 12'd0; r.bottom = 12'd3;
            add_item(vrsd_pkg::KIND_RECT, r, 32'(100 + i));
            add_item(vrsd_pkg::KIND_RECT, r, 32'(100 + i));
        end
        // future timestamp is never stale
        add_item(vrsd_pkg::KIND_CHECK, '0, 32'd50);
        drain();

        // start count zero with a clear, then start count 255: candidate table fills
        write_reg(vrsd_pkg::REG_START_COUNT, 31'd0);
        write_reg(vrsd_pkg::REG_MIN_AREA, 31'h00ff_ffff);
        write_reg(vrsd_pkg::REG_CAND_TIMEOUT, 31'd0);
        write_reg(vrsd_pkg::REG_STRM_TIMEOUT, 31'd0);
        add_item(vrsd_pkg::KIND_CLEAR, '0, 32'd0);
        drain();
        write_reg(vrsd_pkg::REG_MIN_AREA, 31'd1);
        write_reg(vrsd_pkg::REG_START_COUNT, 31'h0000_00ff);
        write_reg(vrsd_pkg::REG_CAND_TIMEOUT, 31'h7fff_ffff);
        for (int i = 0; i < 20; i++)
        begin
            r.left = 12'd0; r.right = 12'(10 + i); r.top = 12'd0; r.bottom = 12'd10;
            add_item(vrsd_pkg::KIND_RECT, r, 32'd1000);
        end
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle = 0;  recv_idle = 0;
                end
                1:
                begin
                    send_idle = 54; recv_idle = 0;
                end
                2:
                begin
                    send_idle = 0;  recv_idle = 54;
                end
                default:
                begin
                    send_idle = 16; recv_idle = 16;
                end
            endcase
            write_reg(vrsd_pkg::REG_MIN_AREA,
                      (ph == 7) ? 31'h00ff_ffff : 31'($urandom_range(200000)));
            write_reg(vrsd_pkg::REG_CAND_TIMEOUT,
                      (ph == 6) ? 31'd0 : 31'($urandom_range(400, 20)));
            write_reg(vrsd_pkg::REG_STRM_TIMEOUT,
                      (ph == 5) ? 31'h7fff_ffff : 31'($urandom_range(2000, 50)));
            write_reg(vrsd_pkg::REG_START_COUNT, 31'($urandom_range(8)));
            random_phase(75);
            drain();
        end

        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
